[src/rnfsa_pkg.sv]
package rnfsa_pkg;

  // Default sizes
  localparam int MAX_SLOTS_DEF = 64;
  localparam int TAG_BITS_DEF  = 16;

  // Fixed field widths
  localparam int CFG_W      = 7;
  localparam int TAG_IN_W   = 16;
  localparam int SLOT_W     = 6;
  localparam int DIST_W     = 6;
  localparam int COST_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 48;

  // Ring size after reset
  localparam logic [CFG_W-1:0] RST_SLOTS = 7'd64;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_NO_TAG = 2'd2
  } status_t;

  // Item mode
  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NORM,
    ST_HEAD_RD,
    ST_HEAD_CK,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_PICK,
    ST_REL_RD,
    ST_REL_CK,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_we;
    logic load;
    logic norm_step;
    logic head_ck;
    logic scan_adv;
    logic scan_ck;
    logic pick_scan;
    logic rel_rd;
    logic rel_ck;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic norm_need;
    logic norm_last;
    logic mode_in;
    logic mode;
    logic head_busy;
    logic k_one;
    logic scan_done;
    logic rel_hit;
    logic rel_end;
    logic out_free;
  } sts_t;

endpackage

[src/ring_nearest_free_slot_allocator_unit.sv]
// Channel | Signals                          | Item contents (low bit up)
// s       | s_tvalid s_tready s_tdata s_tuser | tdata: tag[15:0]; tuser: mode
// m       | m_tvalid m_tready m_tdata m_tuser | tdata: slot_index, distance,
//         |                                   | total_cost, zero pad; tuser: status
// cfg     | cfg_we cfg_wdata                  | slots_in_use[6:0]
//
// Allocate with a free head slot: the accept is followed by HEAD_RD, HEAD_CK and DONE.
// Allocate with a busy head: each scan step is a read state and a check state; the scan runs both
// directions at once on the two read ports of the slot store, up to k-1 steps.
// Release: slots are examined from slot 0, up to k, each with a read and a check state.
// A head left outside a shrunk ring is first reduced mod k (bit-serial mod).
// After reset a clearing pass over all MAX_SLOTS slots runs before the first item.
// A result waits in the output register; a stalled output holds the next item.
module ring_nearest_free_slot_allocator_unit #(
  parameter int MAX_SLOTS = rnfsa_pkg::MAX_SLOTS_DEF,
  parameter int TAG_BITS  = rnfsa_pkg::TAG_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [rnfsa_pkg::CFG_W-1:0]      cfg_wdata,   // slots_in_use
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rnfsa_pkg::TAG_IN_W-1:0]   s_tdata,     // tag
  input  logic                             s_tuser,     // mode
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rnfsa_pkg::OUT_DATA_W-1:0] m_tdata,     // slot_index, distance, total_cost
  output logic [rnfsa_pkg::STATUS_W-1:0]   m_tuser      // status
);

  rnfsa_pkg::cmd_t cmd;
  rnfsa_pkg::sts_t sts;

  // Sequencer
  rnfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot store, search registers and result register
  rnfsa_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[src/rnfsa_ctrl.sv]
module rnfsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  rnfsa_pkg::sts_t sts,
  output rnfsa_pkg::cmd_t cmd
);

  rnfsa_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnfsa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      rnfsa_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_next = rnfsa_pkg::ST_IDLE;
        end
      end
      rnfsa_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.norm_need) begin
            state_next = rnfsa_pkg::ST_NORM;
          end else if (sts.mode_in == rnfsa_pkg::MODE_RELEASE) begin
            state_next = rnfsa_pkg::ST_REL_RD;
          end else begin
            state_next = rnfsa_pkg::ST_HEAD_RD;
          end
        end
      end
      rnfsa_pkg::ST_NORM: begin
        cmd.norm_step = 1'b1;
        if (sts.norm_last) begin
          if (sts.mode == rnfsa_pkg::MODE_RELEASE) begin
            state_next = rnfsa_pkg::ST_REL_RD;
          end else begin
            state_next = rnfsa_pkg::ST_HEAD_RD;
          end
        end
      end
      rnfsa_pkg::ST_HEAD_RD: begin
        state_next = rnfsa_pkg::ST_HEAD_CK;
      end
      rnfsa_pkg::ST_HEAD_CK: begin
        cmd.head_ck = 1'b1;
        if (!sts.head_busy || sts.k_one) begin
          state_next = rnfsa_pkg::ST_DONE;
        end else begin
          state_next = rnfsa_pkg::ST_SCAN_RD;
        end
      end
      rnfsa_pkg::ST_SCAN_RD: begin
        cmd.scan_adv = 1'b1;
        state_next   = rnfsa_pkg::ST_SCAN_CK;
      end
      rnfsa_pkg::ST_SCAN_CK: begin
        cmd.scan_ck = 1'b1;
        if (sts.scan_done) begin
          state_next = rnfsa_pkg::ST_PICK;
        end else begin
          state_next = rnfsa_pkg::ST_SCAN_RD;
        end
      end
      rnfsa_pkg::ST_PICK: begin
        cmd.pick_scan = 1'b1;
        state_next    = rnfsa_pkg::ST_DONE;
      end
      rnfsa_pkg::ST_REL_RD: begin
        cmd.rel_rd = 1'b1;
        state_next = rnfsa_pkg::ST_REL_CK;
      end
      rnfsa_pkg::ST_REL_CK: begin
        cmd.rel_ck = 1'b1;
        if (sts.rel_hit || sts.rel_end) begin
          state_next = rnfsa_pkg::ST_DONE;
        end else begin
          state_next = rnfsa_pkg::ST_REL_RD;
        end
      end
      rnfsa_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = rnfsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rnfsa_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

[src/rnfsa_dp.sv]
module rnfsa_dp #(
  parameter int MAX_SLOTS = rnfsa_pkg::MAX_SLOTS_DEF,
  parameter int TAG_BITS  = rnfsa_pkg::TAG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rnfsa_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic [rnfsa_pkg::TAG_IN_W-1:0]      s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rnfsa_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [rnfsa_pkg::STATUS_W-1:0]      m_tuser,
  input  rnfsa_pkg::cmd_t                     cmd,
  output rnfsa_pkg::sts_t                     sts
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (CNT_W > rnfsa_pkg::CFG_W) ? CNT_W : rnfsa_pkg::CFG_W;
  localparam int BC_W  = $clog2(IDX_W + 1);
  localparam int PAD_W = rnfsa_pkg::OUT_DATA_W - rnfsa_pkg::SLOT_W - rnfsa_pkg::DIST_W
                         - rnfsa_pkg::COST_W;

  // Slot store: busy flag on top of the tag
  logic [TAG_BITS:0] mem [MAX_SLOTS];
  logic [TAG_BITS:0] rd_a, rd_b;
  logic [IDX_W-1:0]  addr_a, addr_b, wr_addr;
  logic [TAG_BITS:0] wr_data;
  logic              wr_en;

  // Persistent state
  logic [rnfsa_pkg::CFG_W-1:0]  slots_in_use;
  logic [IDX_W-1:0]             head_position;
  logic [rnfsa_pkg::COST_W-1:0] cost_total;
  logic [IDX_W-1:0]             clr_ptr;

  // Per-item working registers
  logic                mode;
  logic [TAG_BITS-1:0] tag_q;
  logic [IDX_W-1:0]    head_eff;
  logic [CNT_W-1:0]    rem;
  logic [BC_W-1:0]     bitcnt;
  logic [IDX_W-1:0]    left, right, rel_ptr;
  logic [CNT_W-1:0]    step;
  logic                lf, rf;
  logic [IDX_W-1:0]    lpick, rpick;
  logic [CNT_W-1:0]    ldist, rdist;
  logic                res_found;
  logic [IDX_W-1:0]    res_pick;
  logic [CNT_W-1:0]    res_dist;

  // Combinational helpers
  logic [CMP_W-1:0]   cfg_ext;
  logic [CNT_W-1:0]   k, k_m1, k_step, step_dist;
  logic [IDX_W-1:0]   k_last, left_dec, right_inc;
  logic [CNT_W:0]     rem_sh, rem_sub;
  logic [CNT_W-1:0]   rem_new;
  logic [IDX_W-1:0]   rel_d;
  logic [CNT_W-1:0]   rel_dw, rel_dist;
  logic               a_busy, b_busy, tag_hit;
  logic [IDX_W-1:0]   pick;
  logic [CNT_W-1:0]   dist_eff;
  rnfsa_pkg::status_t status;

  // Ring size, clamped to 1..MAX_SLOTS
  always_comb begin
    cfg_ext = CMP_W'(slots_in_use);
    if (slots_in_use == '0) begin
      k = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_SLOTS)) begin
      k = CNT_W'(MAX_SLOTS);
    end else begin
      k = CNT_W'(cfg_ext);
    end
    k_m1   = k - CNT_W'(1);
    k_last = IDX_W'(k_m1);
  end

  // Ring pointer stepping and step distance
  always_comb begin
    left_dec  = (left == '0) ? k_last : left - IDX_W'(1);
    right_inc = (right == k_last) ? '0 : right + IDX_W'(1);
    k_step    = k - step;
    step_dist = (step < k_step) ? step : k_step;
  end

  // One restoring step of head mod k
  always_comb begin
    rem_sh  = {rem, head_eff[IDX_W-1]};
    rem_sub = rem_sh - {1'b0, k};
    rem_new = (rem_sh >= {1'b0, k}) ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  end

  // Circular distance from head to release pointer
  always_comb begin
    rel_d    = (head_eff > rel_ptr) ? head_eff - rel_ptr : rel_ptr - head_eff;
    rel_dw   = k - CNT_W'(rel_d);
    rel_dist = (rel_dw < CNT_W'(rel_d)) ? rel_dw : CNT_W'(rel_d);
  end

  assign a_busy  = rd_a[TAG_BITS];
  assign b_busy  = rd_b[TAG_BITS];
  assign tag_hit = a_busy && (rd_a[TAG_BITS-1:0] == tag_q);

  // Read address selection
  always_comb begin
    if (cmd.scan_adv) begin
      addr_a = left_dec;
    end else if (cmd.rel_rd) begin
      addr_a = rel_ptr;
    end else begin
      addr_a = head_eff;
    end
    addr_b = right_inc;
  end

  // Final result fields
  always_comb begin
    pick     = res_found ? res_pick : head_eff;
    dist_eff = res_found ? res_dist : '0;
    if (res_found) begin
      status = rnfsa_pkg::STAT_OK;
    end else if (mode == rnfsa_pkg::MODE_RELEASE) begin
      status = rnfsa_pkg::STAT_NO_TAG;
    end else begin
      status = rnfsa_pkg::STAT_FULL;
    end
  end

  // Write port: clearing pass or commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_ptr;
    wr_data = '0;
    if (cmd.clr_we) begin
      wr_en = 1'b1;
    end else if (cmd.commit && res_found) begin
      wr_en   = 1'b1;
      wr_addr = res_pick;
      wr_data = {(mode == rnfsa_pkg::MODE_ALLOC), tag_q};
    end
  end

  // Slot store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= rnfsa_pkg::RST_SLOTS;
    end else if (cfg_we) begin
      slots_in_use <= cfg_wdata;
    end
  end

  // Clearing pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_we) begin
      clr_ptr <= clr_ptr + IDX_W'(1);
    end
  end

  // Head and cost total
  always_ff @(posedge clk) begin
    if (rst) begin
      head_position <= '0;
      cost_total    <= '0;
    end else if (cmd.commit && res_found) begin
      head_position <= res_pick;
      cost_total    <= cost_total + rnfsa_pkg::COST_W'(res_dist);
    end
  end

  // Item working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode      <= s_tuser;
      tag_q     <= TAG_BITS'(s_tdata);
      head_eff  <= head_position;
      rem       <= '0;
      bitcnt    <= '0;
      rel_ptr   <= '0;
      res_found <= 1'b0;
    end
    if (cmd.norm_step) begin
      rem    <= rem_new;
      bitcnt <= bitcnt + BC_W'(1);
      if (sts.norm_last) begin
        head_eff <= IDX_W'(rem_new);
      end else begin
        head_eff <= head_eff << 1;
      end
    end
    if (cmd.head_ck) begin
      left  <= head_eff;
      right <= head_eff;
      step  <= '0;
      lf    <= 1'b0;
      rf    <= 1'b0;
      if (!a_busy) begin
        res_found <= 1'b1;
        res_pick  <= head_eff;
        res_dist  <= '0;
      end
    end
    if (cmd.scan_adv) begin
      left  <= left_dec;
      right <= right_inc;
      step  <= step + CNT_W'(1);
    end
    if (cmd.scan_ck) begin
      if (!lf && !a_busy) begin
        lf    <= 1'b1;
        lpick <= left;
        ldist <= step_dist;
      end
      if (!rf && !b_busy) begin
        rf    <= 1'b1;
        rpick <= right;
        rdist <= step_dist;
      end
    end
    if (cmd.pick_scan) begin
      res_found <= lf && rf;
      // left wins only when strictly closer
      if (ldist < rdist) begin
        res_pick <= lpick;
        res_dist <= ldist;
      end else begin
        res_pick <= rpick;
        res_dist <= rdist;
      end
    end
    if (cmd.rel_ck) begin
      if (tag_hit) begin
        res_found <= 1'b1;
        res_pick  <= rel_ptr;
        res_dist  <= rel_dist;
      end else begin
        rel_ptr <= rel_ptr + IDX_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{PAD_W{1'b0}},
                  cost_total + rnfsa_pkg::COST_W'(dist_eff),
                  rnfsa_pkg::DIST_W'(dist_eff),
                  rnfsa_pkg::SLOT_W'(pick)};
      m_tuser <= status;
    end
  end

  // Status to controller
  always_comb begin
    sts.clr_last  = (clr_ptr == IDX_W'(MAX_SLOTS - 1));
    sts.norm_need = (CNT_W'(head_position) >= k);
    sts.norm_last = (bitcnt == BC_W'(IDX_W - 1));
    sts.mode_in   = s_tuser;
    sts.mode      = mode;
    sts.head_busy = a_busy;
    sts.k_one     = (k == CNT_W'(1));
    sts.scan_done = ((lf || !a_busy) && (rf || !b_busy)) || (step == k_m1);
    sts.rel_hit   = tag_hit;
    sts.rel_end   = (rel_ptr == k_last);
    sts.out_free  = !m_tvalid || m_tready;
  end

  // The head is inside the ring whenever slots are examined
  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    (cmd.head_ck || cmd.rel_ck) |-> (CNT_W'(head_eff) < k))
    else $error("effective head outside ring");

  // A successful move never exceeds half the ring
  a_dist_half: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && res_found) |-> ({res_dist, 1'b0} <= {1'b0, k}))
    else $error("move distance above half ring");

  // The head follows the committed slot
  a_head_moves: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && res_found) |=> (head_position == $past(res_pick)))
    else $error("head did not move to chosen slot");

  // A result appears only from a commit
  a_out_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.commit))
    else $error("result without commit");

endmodule
